/* hdl/nonce_replay_and_timestamp_guard_defines.svh */
// Assertion macros shared by the RTL files.
`ifndef NONCE_REPLAY_AND_TIMESTAMP_GUARD_DEFINES_SVH
`define NONCE_REPLAY_AND_TIMESTAMP_GUARD_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define NRG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define NRG_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define NRG_ASSERT(lbl, prop, msg)
`define NRG_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

/* hdl/nrg_pkg.sv */
package nrg_pkg;

  localparam int unsigned NonceDepth = 64;
  localparam int unsigned HeadW      = (NonceDepth > 1) ? $clog2(NonceDepth) : 1;
  localparam int unsigned NonceW     = 32;
  localparam int unsigned WallW      = 40;
  localparam int unsigned MsgTimeW   = 41;
  localparam int unsigned DiffW      = 43;
  localparam int unsigned WindowW    = 16;
  localparam int unsigned DataW      = 64;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned RegIdxW    = 2;

  localparam logic [RegIdxW-1:0] RegKeyLoaded  = 2'd0;
  localparam logic [RegIdxW-1:0] RegTimeWindow = 2'd1;
  localparam logic [RegIdxW-1:0] RegTrustThr   = 2'd2;

  localparam logic [WindowW-1:0] WindowRst = 16'd60;
  localparam logic [WallW-1:0]   TrustRst  = 40'd1700000000;

  typedef enum logic [2:0] {
    StOk     = 3'd0,
    StNoKey  = 3'd1,
    StTime   = 3'd2,
    StReplay = 3'd3,
    StBadSig = 3'd4
  } status_e;

  typedef enum logic {
    CmdVerify = 1'b0,
    CmdClear  = 1'b1
  } cmd_e;

  typedef struct packed {
    logic               key_loaded;
    logic [WindowW-1:0] window;
    logic [WallW-1:0]   trust_thr;
  } cfg_t;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic [NonceW-1:0] nonce;
  } win_req_t;

endpackage

/* hdl/nrg_regs.sv */
module nrg_regs
  import nrg_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  logic               key_q;
  logic [WindowW-1:0] window_q;
  logic [WallW-1:0]   thr_q;
  logic [RegIdxW-1:0] idx;
  logic               wr_en;

  assign idx    = paddr[AddrW-1:AddrW-RegIdxW];
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q    <= 1'b0;
      window_q <= WindowRst;
      thr_q    <= TrustRst;
    end else if (wr_en) begin
      case (idx)
        RegKeyLoaded:  key_q    <= pwdata[0];
        RegTimeWindow: window_q <= pwdata[WindowW-1:0];
        RegTrustThr:   thr_q    <= pwdata[WallW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegKeyLoaded:  prdata = DataW'(key_q);
      RegTimeWindow: prdata = DataW'(window_q);
      RegTrustThr:   prdata = DataW'(thr_q);
      default:       prdata = '0;
    endcase
  end

  assign cfg_o = '{key_loaded: key_q, window: window_q, trust_thr: thr_q};

endmodule

/* hdl/nrg_window.sv */
`include "nonce_replay_and_timestamp_guard_defines.svh"

module nrg_window
  import nrg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  win_req_t req_i,
  output logic     seen_o
);

  logic [NonceW-1:0]     store_q [NonceDepth];
  logic [NonceDepth-1:0] vld_q;
  logic [HeadW-1:0]      head_q;
  logic [HeadW-1:0]      head_d;
  logic [NonceDepth-1:0] hit;

  always_ff @(posedge clk_i) begin
    if (req_i.push) begin
      store_q[head_q] <= req_i.nonce;
    end
  end

  always_comb begin
    head_d = head_q;
    if (req_i.clear) begin
      head_d = '0;
    end else if (req_i.push) begin
      if (head_q == HeadW'(NonceDepth - 1)) begin
        head_d = '0;
      end else begin
        head_d = head_q + HeadW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      vld_q  <= '0;
    end else begin
      head_q <= head_d;
      if (req_i.clear) begin
        vld_q <= '0;
      end else if (req_i.push) begin
        vld_q[head_q] <= 1'b1;
      end
    end
  end

  // zero never matches
  always_comb begin
    for (int i = 0; i < NonceDepth; i++) begin
      hit[i] = vld_q[i] && (store_q[i] == req_i.nonce);
    end
  end

  assign seen_o = (|hit) && (req_i.nonce != '0);

  `NRG_ASSERT(a_clear_empties, req_i.clear |=> (head_q == '0) && (vld_q == '0), "clear left entries")
  `NRG_ASSERT(a_push_fills, req_i.push && !req_i.clear |=> vld_q != '0, "push left store empty")
  `NRG_ASSERT(a_head_holds, !req_i.push && !req_i.clear |=> $stable(head_q), "head moved")

endmodule

/* hdl/nonce_replay_and_timestamp_guard.sv */
// Channel  | Ports                                         | Dir | Handshake
// command  | command_i nonce_i msg_time_i wall_time_i      | in  | start & !busy
//          | mac_match_i                                   |     |
// result   | status_o                                      | out | result_valid_o, 1 cycle
// config   | psel penable pwrite paddr pwdata prdata       | in  | APB, pready tied high
//
// One word per cycle: busy stays low. A word is registered, checked against the
// window registers and the nonce store, and its status is then registered.
// The nonce store and ring head update at the edge that registers the status, so the
// following word sees them. Reset clears the valid bits of all store entries at once.
// The receiver cannot stall; each status is shown for one cycle.
`include "nonce_replay_and_timestamp_guard_defines.svh"

module nonce_replay_and_timestamp_guard
  import nrg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       command_i,
  input  logic [NonceW-1:0]          nonce_i,
  input  logic signed [MsgTimeW-1:0] msg_time_i,
  input  logic [WallW-1:0]           wall_time_i,
  input  logic                       mac_match_i,
  output logic                       result_valid_o,
  output logic [2:0]                 status_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [AddrW-1:0]           paddr,
  input  logic [DataW-1:0]           pwdata,
  output logic [DataW-1:0]           prdata,
  output logic                       pready
);

  cfg_t                       cfg;
  win_req_t                   win_req;
  logic                       seen;
  logic                       accept;
  logic                       item_vld_q;
  cmd_e                       cmd_q;
  logic [NonceW-1:0]          nonce_q;
  logic signed [MsgTimeW-1:0] msg_q;
  logic [WallW-1:0]           wall_q;
  logic                       mac_q;
  logic signed [DiffW-1:0]    wall_s;
  logic signed [DiffW-1:0]    msg_s;
  logic signed [DiffW-1:0]    win_s;
  logic signed [DiffW-1:0]    diff_fwd;
  logic signed [DiffW-1:0]    diff_rev;
  logic                       late;
  status_e                    status_d;
  status_e                    status_q;
  logic                       result_valid_q;

  nrg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(command_i);
      nonce_q <= nonce_i;
      msg_q   <= msg_time_i;
      wall_q  <= wall_time_i;
      mac_q   <= mac_match_i;
    end
  end

  assign wall_s   = $signed({{(DiffW-WallW){1'b0}}, wall_q});
  assign msg_s    = $signed({{(DiffW-MsgTimeW){msg_q[MsgTimeW-1]}}, msg_q});
  assign win_s    = $signed({{(DiffW-WindowW){1'b0}}, cfg.window});
  assign diff_fwd = wall_s - msg_s;
  assign diff_rev = msg_s - wall_s;
  assign late     = (wall_q >= cfg.trust_thr) && ((diff_fwd > win_s) || (diff_rev > win_s));

  always_comb begin
    if (cmd_q == CmdClear) begin
      status_d = StOk;
    end else if (!cfg.key_loaded) begin
      status_d = StNoKey;
    end else if (late) begin
      status_d = StTime;
    end else if (seen) begin
      status_d = StReplay;
    end else if (!mac_q) begin
      status_d = StBadSig;
    end else begin
      status_d = StOk;
    end
  end

  assign win_req = '{
    clear: item_vld_q && (cmd_q == CmdClear),
    push:  item_vld_q && (cmd_q == CmdVerify) && (status_d == StOk),
    nonce: nonce_q
  };

  nrg_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (win_req),
    .seen_o (seen)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= item_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_vld_q) begin
      status_q <= status_d;
    end
  end

  assign result_valid_o = result_valid_q;
  assign status_o       = status_q;

  `NRG_ASSERT(a_word_yields_status, accept |=> ##1 result_valid_o, "status lost")
  `NRG_ASSERT(a_no_spurious_status, !item_vld_q |=> !result_valid_o, "status without word")
  `NRG_ASSERT_NEVER(a_push_only_on_ok, win_req.push && (status_d != StOk), "failed word stored")

endmodule
